// File: rtl/core/hac_pkg.sv
`default_nettype none

package hac_pkg;

   localparam int MUL_LAT = 3;
   localparam int COS_W = 16;
   localparam logic [COS_W:0] COS_ONE = 17'd32768;

   typedef struct packed {
      logic signed [23:0] ax;
      logic signed [23:0] ay;
      logic signed [23:0] az;
      logic [22:0]        ae;
      logic signed [24:0] px;
      logic signed [24:0] py;
      logic signed [24:0] pz;
      logic [23:0]        pe;
      logic               zero_mom;
   } item_type;

endpackage

`default_nettype wire

// File: rtl/core/helicity_angle_cosine.sv
`default_nettype none

// Helicity angle |cos theta*| of a photon pair. Each transaction carries two photon
// four-vectors in 1/64 GeV units; the result is |cos| in unsigned Q1.15 (32768 = 1.0),
// rounded down, with rsp_valid_res low and the cosine zero when the parent has no
// momentum, is not timelike, or the boosted photon has no momentum. The block takes one
// transaction per clock and returns one result per clock, in order. The path runs through
// a queue of QUEUE_DEPTH entries, the product and sum stages, two banks of pipelined
// 32x32 partial-product multipliers, and a sixteen-stage square-root division pipeline
// that settles one result bit per stage. Stalls on the result side hold the whole
// pipeline; the queue keeps taking input until it is full.
module helicity_angle_cosine import hac_pkg::*; #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [23:0] req_photon1_px,
   input  logic signed [23:0] req_photon1_py,
   input  logic signed [23:0] req_photon1_pz,
   input  logic [22:0]        req_photon1_energy,
   input  logic signed [23:0] req_photon2_px,
   input  logic signed [23:0] req_photon2_py,
   input  logic signed [23:0] req_photon2_pz,
   input  logic [22:0]        req_photon2_energy,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [15:0]        rsp_abs_cosine,
   output logic               rsp_valid_res
);

   logic     q_full;
   logic     q_empty;
   logic     push;
   logic     pop;
   item_type push_item;
   item_type head;

   hac_front u_front (
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_photon1_px     (req_photon1_px),
      .req_photon1_py     (req_photon1_py),
      .req_photon1_pz     (req_photon1_pz),
      .req_photon1_energy (req_photon1_energy),
      .req_photon2_px     (req_photon2_px),
      .req_photon2_py     (req_photon2_py),
      .req_photon2_pz     (req_photon2_pz),
      .req_photon2_energy (req_photon2_energy),
      .q_full             (q_full),
      .push               (push),
      .item               (push_item)
   );

   hac_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .full      (q_full),
      .pop       (pop),
      .empty     (q_empty),
      .head      (head)
   );

   hac_back u_back (
      .clock          (clock),
      .reset          (reset),
      .q_empty        (q_empty),
      .q_pop          (pop),
      .head           (head),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_abs_cosine (rsp_abs_cosine),
      .rsp_valid_res  (rsp_valid_res)
   );

endmodule

`default_nettype wire

// File: rtl/core/hac_front.sv
`default_nettype none

module hac_front import hac_pkg::*; (
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [23:0] req_photon1_px,
   input  logic signed [23:0] req_photon1_py,
   input  logic signed [23:0] req_photon1_pz,
   input  logic [22:0]        req_photon1_energy,
   input  logic signed [23:0] req_photon2_px,
   input  logic signed [23:0] req_photon2_py,
   input  logic signed [23:0] req_photon2_pz,
   input  logic [22:0]        req_photon2_energy,
   input  logic               q_full,
   output logic               push,
   output item_type           item
);

   logic signed [24:0] px;
   logic signed [24:0] py;
   logic signed [24:0] pz;

   assign px = 25'(req_photon1_px) + 25'(req_photon2_px);
   assign py = 25'(req_photon1_py) + 25'(req_photon2_py);
   assign pz = 25'(req_photon1_pz) + 25'(req_photon2_pz);

   assign req_ready = !q_full;
   assign push      = req_valid && !q_full;

   always_comb begin
      item.ax       = req_photon1_px;
      item.ay       = req_photon1_py;
      item.az       = req_photon1_pz;
      item.ae       = req_photon1_energy;
      item.px       = px;
      item.py       = py;
      item.pz       = pz;
      item.pe       = 24'(req_photon1_energy) + 24'(req_photon2_energy);
      // parent at rest in the lab: no axis to measure against
      item.zero_mom = (px == '0) && (py == '0) && (pz == '0);
   end

endmodule

`default_nettype wire

// File: rtl/core/hac_queue.sv
`default_nettype none

module hac_queue import hac_pkg::*; #(
   parameter int DEPTH = 4
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type push_item,
   output logic     full,
   input  logic     pop,
   output logic     empty,
   output item_type head
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   item_type        mem_ff [DEPTH];
   logic [AW-1:0]   wr_ptr_ff;
   logic [AW-1:0]   wr_ptr_in;
   logic [AW-1:0]   rd_ptr_ff;
   logic [AW-1:0]   rd_ptr_in;
   logic [CW-1:0]   count_ff;
   logic [CW-1:0]   count_in;

   assign full  = (count_ff == CW'(DEPTH));
   assign empty = (count_ff == '0);
   assign head  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

`default_nettype wire

// File: rtl/core/hac_mul.sv
`default_nettype none

module hac_mul #(
   parameter int AW = 32,
   parameter int BW = 32
) (
   input  logic             clock,
   input  logic             en,
   input  logic [AW-1:0]    a,
   input  logic [BW-1:0]    b,
   output logic [AW+BW-1:0] p
);

   localparam int NA = (AW + 31) / 32;
   localparam int NB = (BW + 31) / 32;
   localparam int AP = NA * 32;
   localparam int BP = NB * 32;
   localparam int RW = (NB + 1) * 32;
   localparam int PW = (NA + NB) * 32;

   logic [AP-1:0] a_pad;
   logic [BP-1:0] b_pad;
   logic [63:0]   pp_in  [NA][NB];
   logic [63:0]   pp_ff  [NA][NB];
   logic [RW-1:0] row_in [NA];
   logic [RW-1:0] row_ff [NA];
   logic [PW-1:0] sum_in;
   logic [PW-1:0] sum_ff;

   assign a_pad = AP'(a);
   assign b_pad = BP'(b);

   always_comb begin
      for (int i = 0; i < NA; i++) begin
         for (int j = 0; j < NB; j++) begin
            pp_in[i][j] = 64'(a_pad[32*i +: 32]) * 64'(b_pad[32*j +: 32]);
         end
      end
   end

   always_comb begin
      for (int i = 0; i < NA; i++) begin
         row_in[i] = '0;
         for (int j = 0; j < NB; j++) begin
            row_in[i] = row_in[i] + (RW'(pp_ff[i][j]) << (32 * j));
         end
      end
   end

   always_comb begin
      sum_in = '0;
      for (int i = 0; i < NA; i++) begin
         sum_in = sum_in + (PW'(row_ff[i]) << (32 * i));
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pp_ff  <= pp_in;
         row_ff <= row_in;
         sum_ff <= sum_in;
      end
   end

   assign p = sum_ff[AW+BW-1:0];

endmodule

`default_nettype wire

// File: rtl/core/hac_back.sv
`default_nettype none

module hac_back import hac_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             q_empty,
   output logic             q_pop,
   input  item_type         head,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [COS_W-1:0] rsp_abs_cosine,
   output logic             rsp_valid_res
);

   localparam int NSTEP = COS_W;
   localparam int DENW  = 149;
   localparam int DW    = 178;
   localparam int RW    = 165;
   localparam int TW    = 183;

   function automatic logic [48:0] sq25(input logic signed [24:0] v);
      logic signed [49:0] w;
      w = 50'(v) * 50'(v);
      return w[48:0];
   endfunction

   function automatic logic [48:0] mag50(input logic signed [49:0] v);
      logic signed [49:0] n;
      n = -v;
      return v[49] ? n[48:0] : v[48:0];
   endfunction

   logic adv;
   logic rsp_valid_ff;
   logic [COS_W-1:0] rsp_cos_ff;
   logic rsp_ok_ff;

   assign adv   = !rsp_valid_ff || rsp_ready;
   assign q_pop = adv && !q_empty;

   // stage 1: narrow products
   logic               s1_valid_ff;
   logic               s1_zero_ff;
   logic [22:0]        s1_ae_ff;
   logic [23:0]        s1_pe_ff;
   logic [48:0]        s1_sqx_ff, s1_sqy_ff, s1_sqz_ff;
   logic [47:0]        s1_pe2_ff;
   logic signed [48:0] s1_dx_ff, s1_dy_ff, s1_dz_ff;
   logic signed [48:0] s1_pyaz_ff, s1_pzay_ff, s1_pzax_ff;
   logic signed [48:0] s1_pxaz_ff, s1_pxay_ff, s1_pyax_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_zero_ff <= head.zero_mom;
         s1_ae_ff   <= head.ae;
         s1_pe_ff   <= head.pe;
         s1_sqx_ff  <= sq25(head.px);
         s1_sqy_ff  <= sq25(head.py);
         s1_sqz_ff  <= sq25(head.pz);
         s1_pe2_ff  <= 48'(head.pe) * 48'(head.pe);
         s1_dx_ff   <= 49'(head.px) * 49'(head.ax);
         s1_dy_ff   <= 49'(head.py) * 49'(head.ay);
         s1_dz_ff   <= 49'(head.pz) * 49'(head.az);
         s1_pyaz_ff <= 49'(head.py) * 49'(head.az);
         s1_pzay_ff <= 49'(head.pz) * 49'(head.ay);
         s1_pzax_ff <= 49'(head.pz) * 49'(head.ax);
         s1_pxaz_ff <= 49'(head.px) * 49'(head.az);
         s1_pxay_ff <= 49'(head.px) * 49'(head.ay);
         s1_pyax_ff <= 49'(head.py) * 49'(head.ax);
      end
   end

   // stage 2: |P|^2, mass check, dot and cross products
   logic [49:0]        s2_pmag2_in;
   logic               s2_valid_ff;
   logic               s2_bad_ff;
   logic [22:0]        s2_ae_ff;
   logic [23:0]        s2_pe_ff;
   logic [49:0]        s2_pmag2_ff;
   logic [47:0]        s2_m2_ff;
   logic signed [49:0] s2_dot_ff;
   logic signed [49:0] s2_cx_ff, s2_cy_ff, s2_cz_ff;

   assign s2_pmag2_in = 50'(s1_sqx_ff) + 50'(s1_sqy_ff) + 50'(s1_sqz_ff);

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_bad_ff   <= s1_zero_ff || (50'(s1_pe2_ff) <= s2_pmag2_in);
         s2_ae_ff    <= s1_ae_ff;
         s2_pe_ff    <= s1_pe_ff;
         s2_pmag2_ff <= s2_pmag2_in;
         s2_m2_ff    <= s1_pe2_ff - s2_pmag2_in[47:0];
         s2_dot_ff   <= 50'(s1_dx_ff) + 50'(s1_dy_ff) + 50'(s1_dz_ff);
         s2_cx_ff    <= 50'(s1_pyaz_ff) - 50'(s1_pzay_ff);
         s2_cy_ff    <= 50'(s1_pzax_ff) - 50'(s1_pxaz_ff);
         s2_cz_ff    <= 50'(s1_pxay_ff) - 50'(s1_pyax_ff);
      end
   end

   // multiplier group 1
   logic [72:0] m1_pd, m1_ep;
   logic [97:0] m1_sx, m1_sy, m1_sz;
   logic [MUL_LAT-1:0] d1_valid_ff;
   logic [MUL_LAT-1:0] d1_bad_ff;
   logic [MUL_LAT-1:0] d1_neg_ff;
   logic [47:0]        d1_m2_ff [MUL_LAT];

   hac_mul #(.AW(24), .BW(49)) u_mul_pd (
      .clock(clock), .en(adv), .a(s2_pe_ff), .b(mag50(s2_dot_ff)), .p(m1_pd));
   hac_mul #(.AW(23), .BW(50)) u_mul_ep (
      .clock(clock), .en(adv), .a(s2_ae_ff), .b(s2_pmag2_ff), .p(m1_ep));
   hac_mul #(.AW(49), .BW(49)) u_mul_sx (
      .clock(clock), .en(adv), .a(mag50(s2_cx_ff)), .b(mag50(s2_cx_ff)), .p(m1_sx));
   hac_mul #(.AW(49), .BW(49)) u_mul_sy (
      .clock(clock), .en(adv), .a(mag50(s2_cy_ff)), .b(mag50(s2_cy_ff)), .p(m1_sy));
   hac_mul #(.AW(49), .BW(49)) u_mul_sz (
      .clock(clock), .en(adv), .a(mag50(s2_cz_ff)), .b(mag50(s2_cz_ff)), .p(m1_sz));

   always_ff @(posedge clock) begin
      if (adv) begin
         d1_bad_ff <= {d1_bad_ff[MUL_LAT-2:0], s2_bad_ff};
         d1_neg_ff <= {d1_neg_ff[MUL_LAT-2:0], s2_dot_ff[49]};
         d1_m2_ff[0] <= s2_m2_ff;
         for (int k = 1; k < MUL_LAT; k++) begin
            d1_m2_ff[k] <= d1_m2_ff[k-1];
         end
      end
   end

   // stage 3: |A| and |P x p|^2
   logic [73:0] s3_sum, s3_d1, s3_d2;
   logic        s3_valid_ff;
   logic        s3_bad_ff;
   logic [73:0] s3_absa_ff;
   logic [97:0] s3_cr_ff;
   logic [47:0] s3_m2_ff;

   assign s3_sum = 74'(m1_pd) + 74'(m1_ep);
   assign s3_d1  = 74'(m1_pd) - 74'(m1_ep);
   assign s3_d2  = 74'(m1_ep) - 74'(m1_pd);

   always_ff @(posedge clock) begin
      if (adv) begin
         s3_bad_ff  <= d1_bad_ff[MUL_LAT-1];
         s3_absa_ff <= d1_neg_ff[MUL_LAT-1] ? s3_sum : ((m1_pd >= m1_ep) ? s3_d1 : s3_d2);
         s3_cr_ff   <= m1_sx + m1_sy + m1_sz;
         s3_m2_ff   <= d1_m2_ff[MUL_LAT-1];
      end
   end

   // multiplier group 2
   logic [147:0] m2_num;
   logic [145:0] m2_mc;
   logic [MUL_LAT-1:0] d2_valid_ff;
   logic [MUL_LAT-1:0] d2_bad_ff;

   hac_mul #(.AW(74), .BW(74)) u_mul_num (
      .clock(clock), .en(adv), .a(s3_absa_ff), .b(s3_absa_ff), .p(m2_num));
   hac_mul #(.AW(48), .BW(98)) u_mul_mc (
      .clock(clock), .en(adv), .a(s3_m2_ff), .b(s3_cr_ff), .p(m2_mc));

   always_ff @(posedge clock) begin
      if (adv) begin
         d2_bad_ff <= {d2_bad_ff[MUL_LAT-2:0], s3_bad_ff};
      end
   end

   // square-root division: largest q with q^2*den <= 2^30*num, one bit per stage
   logic [NSTEP:0]    sv_in,   sv_ff;
   logic [NSTEP:0]    sb_in,   sb_ff;
   logic [DENW-1:0]   sd_in    [NSTEP+1];
   logic [DENW-1:0]   sd_ff    [NSTEP+1];
   logic [DW-1:0]     srem_in  [NSTEP+1];
   logic [DW-1:0]     srem_ff  [NSTEP+1];
   logic [RW-1:0]     srr_in   [NSTEP+1];
   logic [RW-1:0]     srr_ff   [NSTEP+1];
   logic [COS_W-1:0]  sq_in    [NSTEP+1];
   logic [COS_W-1:0]  sq_ff    [NSTEP+1];

   assign sv_in = {sv_ff[NSTEP-1:0], d2_valid_ff[MUL_LAT-1]};
   assign sb_in = {sb_ff[NSTEP-1:0],
                   d2_bad_ff[MUL_LAT-1] || ((m2_num == '0) && (m2_mc == '0))};
   assign sd_in[0]   = DENW'(m2_num) + DENW'(m2_mc);
   assign srem_in[0] = {m2_num, 30'b0};
   assign srr_in[0]  = '0;
   assign sq_in[0]   = '0;

   for (genvar k = 0; k < NSTEP; k++) begin : g_step
      localparam int B = NSTEP - 1 - k;
      logic [TW-1:0] diff;
      logic          take;

      assign diff = TW'(srem_ff[k]) - (TW'(srr_ff[k]) << (B + 1))
                    - (TW'(sd_ff[k]) << (2 * B));
      assign take = !diff[TW-1];

      assign sd_in[k+1]   = sd_ff[k];
      assign srem_in[k+1] = take ? diff[DW-1:0] : srem_ff[k];
      assign srr_in[k+1]  = take ? srr_ff[k] + (RW'(sd_ff[k]) << B) : srr_ff[k];
      assign sq_in[k+1]   = take ? (sq_ff[k] | (COS_W'(1) << B)) : sq_ff[k];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sb_ff   <= sb_in;
         sd_ff   <= sd_in;
         srem_ff <= srem_in;
         srr_ff  <= srr_in;
         sq_ff   <= sq_in;
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         d1_valid_ff  <= '0;
         s3_valid_ff  <= 1'b0;
         d2_valid_ff  <= '0;
         sv_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff  <= !q_empty;
         s2_valid_ff  <= s1_valid_ff;
         d1_valid_ff  <= {d1_valid_ff[MUL_LAT-2:0], s2_valid_ff};
         s3_valid_ff  <= d1_valid_ff[MUL_LAT-1];
         d2_valid_ff  <= {d2_valid_ff[MUL_LAT-2:0], s3_valid_ff};
         sv_ff        <= sv_in;
         rsp_valid_ff <= sv_ff[NSTEP];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_cos_ff <= sb_ff[NSTEP] ? '0 : sq_ff[NSTEP];
         rsp_ok_ff  <= !sb_ff[NSTEP];
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_abs_cosine = rsp_cos_ff;
   assign rsp_valid_res  = rsp_ok_ff;

endmodule

`default_nettype wire

// File: rtl/core/hac_checker.sv
`default_nettype none

module hac_checker import hac_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [15:0] rsp_abs_cosine,
   input logic        rsp_valid_res
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result transaction dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_abs_cosine) && $stable(rsp_valid_res))
      else $error("result payload changed while stalled");

   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_valid_res |-> rsp_abs_cosine == '0)
      else $error("degenerate result with nonzero cosine");

   a_cos_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> {1'b0, rsp_abs_cosine} <= COS_ONE)
      else $error("cosine above one");

endmodule

bind helicity_angle_cosine hac_checker u_hac_checker (.*);

`default_nettype wire

// File: tb/sv/helicity_angle_cosine_tb.sv
module helicity_angle_cosine_tb;
   import hac_pkg::*;

   typedef struct {
      logic signed [23:0] p1x, p1y, p1z;
      logic [22:0]        p1e;
      logic signed [23:0] p2x, p2y, p2z;
      logic [22:0]        p2e;
      bit                 drain_first;
   } photon_pair_type;

   typedef struct {
      logic [15:0] abs_cosine;
      logic        valid_res;
   } helicity_type;

   localparam int TIMEOUT_CYCLES = 1000000;
   localparam int NUM_RANDOM = 1850;
   localparam int DRAIN_CYCLES = 60;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic signed [23:0] req_photon1_px = '0, req_photon1_py = '0, req_photon1_pz = '0;
   logic [22:0]        req_photon1_energy = '0;
   logic signed [23:0] req_photon2_px = '0, req_photon2_py = '0, req_photon2_pz = '0;
   logic [22:0]        req_photon2_energy = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [15:0]        rsp_abs_cosine;
   logic               rsp_valid_res;

   photon_pair_type pending_pairs[$];
   helicity_type    expected_cosines[$];
   int           failures = 0;
   int           cycle_count = 0;
   int           pairs_sent = 0;
   bit           req_taken = 1'b0;
   bit           stim_done = 1'b0;
   int           send_gap = 0;
   int           recv_gap = 0;
   bit           long_hold_done = 1'b0;

   helicity_angle_cosine u_dut (.*);

   always #2 clock = ~clock;

   function automatic helicity_type cos_theta_star(photon_pair_type pp);
      logic signed [255:0] ax, ay, az, ae, px, py, pz, pe;
      logic signed [255:0] pmag2, m2, dot, cx, cy, cz, a, num, cr, den, lim, t;
      helicity_type r;
      r.abs_cosine = '0;
      r.valid_res = 1'b0;
      ax = pp.p1x; ay = pp.p1y; az = pp.p1z; ae = pp.p1e;
      px = ax + pp.p2x; py = ay + pp.p2y; pz = az + pp.p2z;
      pe = ae + pp.p2e;
      pmag2 = px * px + py * py + pz * pz;
      m2 = pe * pe - pmag2;
      if (pmag2 == 0 || m2 <= 0) return r;
      dot = px * ax + py * ay + pz * az;
      cx = py * az - pz * ay;
      cy = pz * ax - px * az;
      cz = px * ay - py * ax;
      a = pe * dot - ae * pmag2;
      num = a * a;
      cr = cx * cx + cy * cy + cz * cz;
      den = num + m2 * cr;
      if (den == 0) return r;
      lim = num <<< 30;
      for (int b = 15; b >= 0; b--) begin
         t = r.abs_cosine | (16'd1 << b);
         if (t * t * den <= lim) r.abs_cosine = t[15:0];
      end
      r.valid_res = 1'b1;
      return r;
   endfunction

   function automatic photon_pair_type make_pair(int x1, int y1, int z1, int e1,
                                                 int x2, int y2, int z2, int e2);
      photon_pair_type pp;
      pp.p1x = x1; pp.p1y = y1; pp.p1z = z1; pp.p1e = e1;
      pp.p2x = x2; pp.p2y = y2; pp.p2z = z2; pp.p2e = e2;
      pp.drain_first = 1'b0;
      return pp;
   endfunction

   // energy on a random scale, momentum components within half of it
   task automatic random_photon(output int x, output int y, output int z, output int e);
      int lim;
      e = $urandom_range(0, (1 << $urandom_range(1, 23)) - 1);
      lim = e / 2;
      x = $urandom_range(0, 2 * lim) - lim;
      y = $urandom_range(0, 2 * lim) - lim;
      z = $urandom_range(0, 2 * lim) - lim;
   endtask

   function automatic int rand_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   initial begin
      int x1, y1, z1, e1, x2, y2, z2, e2, mode;
      photon_pair_type pp;
      pending_pairs.push_back(make_pair(0, 0, 0, 0, 0, 0, 0, 0));
      pending_pairs.push_back(make_pair(8388607, 8388607, 8388607, 8388607,
                                        8388607, 8388607, 8388607, 8388607));
      pending_pairs.push_back(make_pair(-8388608, -8388608, -8388608, 8388607,
                                        -8388608, -8388608, -8388608, 8388607));
      pending_pairs.push_back(make_pair(1, -1, 1, 8388607, 0, 0, 0, 8388607));
      pending_pairs.push_back(make_pair(8388607, 0, 0, 8388607, 0, -8388608, 0, 8388607));
      pending_pairs.push_back(make_pair(300, -200, 50, 500, -300, 200, -50, 500));
      pending_pairs.push_back(make_pair(0, 0, 1000, 1000, 0, 0, 2000, 2000));
      pending_pairs.push_back(make_pair(0, 0, 5, 3, 0, 0, 5, 3));
      pending_pairs.push_back(make_pair(1, 0, 1, 2, -1, 0, 1, 2));
      pending_pairs.push_back(make_pair(0, 0, 100, 200, 0, 0, -10, 300));
      pending_pairs.push_back(make_pair(0, 0, 0, 5, 0, 0, 0, 7));
      pending_pairs.push_back(make_pair(3, 4, 0, 5, 0, 0, 0, 0));
      pending_pairs.push_back(make_pair(-4194304, 4194303, -1, 8388607,
                                        4194303, 2097152, 1, 6000000));
      for (int i = 0; i < NUM_RANDOM; i++) begin
         mode = $urandom_range(0, 99);
         random_photon(x1, y1, z1, e1);
         random_photon(x2, y2, z2, e2);
         if (mode < 10) begin
            x1 = $urandom; y1 = $urandom; z1 = $urandom; e1 = $urandom;
            x2 = $urandom; y2 = $urandom; z2 = $urandom; e2 = $urandom;
         end else if (mode < 15) begin
            x2 = -x1; y2 = -y1; z2 = -z1;
         end else if (mode < 20) begin
            x2 = x1; y2 = y1; z2 = z1; e2 = e1;
         end
         pp = make_pair(x1, y1, z1, e1, x2, y2, z2, e2);
         pp.drain_first = (i == 500 || i == 1300);
         pending_pairs.push_back(pp);
      end
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      do begin
         @(posedge clock);
      end while (pending_pairs.size() != 0 || req_valid || expected_cosines.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failures == 0 && expected_cosines.size() == 0) begin
         $display("helicity_angle_cosine test passed");
      end else begin
         $display("helicity_angle_cosine test failed");
      end
      $finish;
   end

   // request driver
   always @(negedge clock) begin
      photon_pair_type pp;
      if (!reset && !(req_valid && !req_taken)) begin
         if (send_gap > 0) begin
            req_valid <= 1'b0;
            send_gap <= send_gap - 1;
         end else if (pending_pairs.size() != 0 &&
                      !(pending_pairs[0].drain_first && expected_cosines.size() != 0)) begin
            pp = pending_pairs.pop_front();
            req_valid <= 1'b1;
            req_photon1_px <= pp.p1x; req_photon1_py <= pp.p1y;
            req_photon1_pz <= pp.p1z; req_photon1_energy <= pp.p1e;
            req_photon2_px <= pp.p2x; req_photon2_py <= pp.p2y;
            req_photon2_pz <= pp.p2z; req_photon2_energy <= pp.p2e;
            pairs_sent <= pairs_sent + 1;
            send_gap <= (pairs_sent > 700 && pairs_sent < 950) ? 0 : rand_gap();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // response ready
   always @(negedge clock) begin
      if (!reset) begin
         if (recv_gap > 0) begin
            rsp_ready <= 1'b0;
            recv_gap <= recv_gap - 1;
         end else if (!long_hold_done && pairs_sent >= 300) begin
            rsp_ready <= 1'b0;
            recv_gap <= 200;
            long_hold_done <= 1'b1;
         end else if (pairs_sent > 700 && pairs_sent < 950) begin
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= 1'b1;
            recv_gap <= rand_gap();
         end
      end
   end

   // monitor and checker
   always @(posedge clock) begin
      photon_pair_type pp;
      helicity_type exp_r;
      cycle_count <= cycle_count + 1;
      if (cycle_count >= TIMEOUT_CYCLES) begin
         $display("helicity_angle_cosine test failed");
         $finish;
      end
      req_taken <= req_valid && req_ready;
      if (!reset && req_valid && req_ready) begin
         pp = make_pair(req_photon1_px, req_photon1_py, req_photon1_pz, req_photon1_energy,
                        req_photon2_px, req_photon2_py, req_photon2_pz, req_photon2_energy);
         expected_cosines.push_back(cos_theta_star(pp));
      end
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_cosines.size() == 0) begin
            $display("%0t: unexpected transaction cos=%0d valid_res=%0b", $time,
                     rsp_abs_cosine, rsp_valid_res);
            failures = failures + 1;
         end else begin
            exp_r = expected_cosines.pop_front();
            if (rsp_abs_cosine !== exp_r.abs_cosine) begin
               $display("%0t: abs_cosine expected %0d actual %0d", $time,
                        exp_r.abs_cosine, rsp_abs_cosine);
               failures = failures + 1;
            end
            if (rsp_valid_res !== exp_r.valid_res) begin
               $display("%0t: valid_res expected %0b actual %0b", $time,
                        exp_r.valid_res, rsp_valid_res);
               failures = failures + 1;
            end
         end
      end
   end

endmodule
